/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* sv/mavg_pkg.sv */
package mavg_pkg;

  localparam int MAX_WINDOW_DEF = 64;
  localparam int SAMPLE_W       = 16;
  localparam int WIN_LEN_W      = 7;
  localparam int SUM_W          = 23;
  localparam int SMOOTH_W       = 32;
  localparam int DIV_W          = 33;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;

  localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = 7'd8;

  localparam logic REG_FILTER_MODE   = 1'b0;
  localparam logic REG_WINDOW_LENGTH = 1'b1;

  localparam logic MODE_BOXCAR = 1'b0;
  localparam logic MODE_EMA    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_KICK,
    ST_WAIT,
    ST_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic                        start;
    logic signed [DIV_W-1:0]     num;
    logic        [WIN_LEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

/* sv/mavg_ram.sv */
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/mavg_div.sv */
module mavg_div (
  input  logic               clk,
  input  logic               rst,
  input  mavg_pkg::div_req_t req,
  output mavg_pkg::div_rsp_t rsp
);

  localparam int DW    = mavg_pkg::DIV_W;
  localparam int NW    = mavg_pkg::WIN_LEN_W;
  localparam int CNT_W = $clog2(DW + 1);

  logic                    busy;
  logic [CNT_W-1:0]        cnt;
  logic [NW-1:0]           rem;
  logic [NW-1:0]           den_r;
  logic [DW-1:0]           quo;
  logic                    neg;
  logic                    done;
  logic signed [DW-1:0]    quot;
  logic [NW:0]             trial;
  logic                    fits;
  logic [NW:0]             trial_sub;

  assign trial     = {rem, quo[DW-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= CNT_W'(DW);
      neg   <= req.num[DW-1];
      quo   <= req.num[DW-1] ? DW'(-req.num) : DW'(req.num);
      rem   <= '0;
      den_r <= req.den;
    end else if (busy && cnt != '0) begin
      rem <= fits ? trial_sub[NW-1:0] : trial[NW-1:0];
      quo <= {quo[DW-2:0], fits};
      cnt <= cnt - CNT_W'(1);
    end else if (busy) begin
      quot <= neg ? -$signed(quo) : $signed(quo);
      done <= 1'b1;
      busy <= 1'b0;
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* sv/moving_average_or_ema_filter_core.sv */
// Moving-average / exponential-smoothing filter for signed Q1.15 samples.
// Requests enter on the s_ stream channel (s_tdata holds one sample) and one
// filtered sample leaves on the m_ stream channel per request.
// The APB port holds filter_mode (0: boxcar average, 1: one-pole smoother)
// at byte address 0 and window_length at byte address 4. Any write clears
// the ring pointer, sample count, running sum and smoothed value; write only
// while no request is in flight.
// Each request passes from acceptance to a valid result through a ring
// read and sum update in boxcar mode, then a shared restoring divider that
// resolves one of 33 quotient bits per cycle, then the result update. The
// core takes no new request until that update is done and it is idle again.
// The result waits in an output register, so a stalled receiver does not
// block the next request; if the register is still full when a new result
// is ready, the core holds that result and s_tready stays low.
// Reset returns the registers to mode 0 and window length 8 and clears all
// filter state. The history ring needs no clearing pass.
`include "assert_macros.svh"

module moving_average_or_ema_filter_core #(
  parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_tdata: sample_in [15:0]
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [15:0]                         s_tdata,
  // m_tdata: sample_out [15:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [15:0]                         m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mavg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [mavg_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int SW    = mavg_pkg::SAMPLE_W;
  localparam int NW    = mavg_pkg::WIN_LEN_W;
  localparam int SUMW  = mavg_pkg::SUM_W;
  localparam int YW    = mavg_pkg::SMOOTH_W;
  localparam int DW    = mavg_pkg::DIV_W;
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int IDX_W = ((PTR_W > NW) ? PTR_W : NW) + 1;
  localparam int N_MAX = (1 << NW) - 1;
  localparam int CAP   = (MAX_WINDOW > N_MAX) ? N_MAX : MAX_WINDOW;
  localparam logic [NW-1:0] N_CAP = NW'(CAP);

  mavg_pkg::fsm_state_t state, state_next;

  logic                   filter_mode;
  logic [NW-1:0]          window_length;
  logic [NW-1:0]          n_eff;
  logic [PTR_W-1:0]       ptr;
  logic [NW-1:0]          held;
  logic signed [SUMW-1:0] sum;
  logic signed [YW-1:0]   smooth;
  logic signed [SW-1:0]   x_reg;
  logic signed [DW-1:0]   div_num;
  logic [NW-1:0]          div_den;
  logic                   cfg_wr;
  logic                   full;
  logic [IDX_W-1:0]       idx_diff;
  logic [IDX_W-1:0]       idx_wrap;
  logic [PTR_W-1:0]       oldest;
  logic [SW-1:0]          ram_rdata;
  logic                   ram_we;
  logic signed [SUMW-1:0] sum_next;
  logic [NW-1:0]          held_next;
  logic signed [YW-1:0]   smooth_next;
  logic [SW-1:0]          result;
  logic                   in_acc;
  logic                   out_free;
  mavg_pkg::div_req_t     div_req;
  mavg_pkg::div_rsp_t     div_rsp;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      mavg_pkg::REG_FILTER_MODE:   prdata = {{(mavg_pkg::CFG_DATA_W-1){1'b0}}, filter_mode};
      mavg_pkg::REG_WINDOW_LENGTH: prdata = {{(mavg_pkg::CFG_DATA_W-NW){1'b0}}, window_length};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode   <= mavg_pkg::MODE_BOXCAR;
      window_length <= mavg_pkg::WIN_LEN_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        mavg_pkg::REG_FILTER_MODE:   filter_mode   <= pwdata[0];
        mavg_pkg::REG_WINDOW_LENGTH: window_length <= pwdata[NW-1:0];
        default:                     filter_mode   <= filter_mode;
      endcase
    end
  end

  assign n_eff = (window_length == '0) ? NW'(1) :
                 (window_length > N_CAP) ? N_CAP : window_length;
  assign full  = held >= n_eff;

  assign idx_diff = IDX_W'(ptr) - IDX_W'(n_eff);
  assign idx_wrap = idx_diff[IDX_W-1] ? idx_diff + IDX_W'(MAX_WINDOW) : idx_diff;
  assign oldest   = idx_wrap[PTR_W-1:0];

  assign ram_we = (state == mavg_pkg::ST_LOAD) && (filter_mode == mavg_pkg::MODE_BOXCAR);

  mavg_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr),
    .wdata (x_reg),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  assign sum_next = sum + SUMW'(x_reg)
                  - (full ? SUMW'($signed(ram_rdata)) : SUMW'(0));
  assign held_next = full ? held : held + NW'(1);

  assign div_req.start = (state == mavg_pkg::ST_KICK);
  assign div_req.num   = div_num;
  assign div_req.den   = div_den;

  mavg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign smooth_next = smooth + div_rsp.quot[YW-1:0];
  assign result = (filter_mode == mavg_pkg::MODE_BOXCAR) ? div_rsp.quot[SW-1:0]
                                                         : smooth_next[YW-1:YW-SW];

  assign s_tready = (state == mavg_pkg::ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mavg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mavg_pkg::ST_IDLE:   if (s_tvalid) state_next = mavg_pkg::ST_LOAD;
      mavg_pkg::ST_LOAD:   state_next = mavg_pkg::ST_KICK;
      mavg_pkg::ST_KICK:   state_next = mavg_pkg::ST_WAIT;
      mavg_pkg::ST_WAIT:   if (div_rsp.done) state_next = mavg_pkg::ST_FINISH;
      mavg_pkg::ST_FINISH: if (out_free) state_next = mavg_pkg::ST_IDLE;
      default:             state_next = mavg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_reg <= s_tdata;
    end
    if (state == mavg_pkg::ST_LOAD) begin
      div_den <= (filter_mode == mavg_pkg::MODE_BOXCAR) ? held_next : n_eff;
      div_num <= (filter_mode == mavg_pkg::MODE_BOXCAR)
               ? DW'(sum_next)
               : $signed({x_reg[SW-1], x_reg, 16'h0000}) - DW'(smooth);
    end
    if (state == mavg_pkg::ST_FINISH && out_free) begin
      m_tdata <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr      <= '0;
      held     <= '0;
      sum      <= '0;
      smooth   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        ptr    <= '0;
        held   <= '0;
        sum    <= '0;
        smooth <= '0;
      end else if (ram_we) begin
        ptr  <= (ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr + PTR_W'(1);
        held <= held_next;
        sum  <= sum_next;
      end else if (state == mavg_pkg::ST_FINISH && out_free &&
                   filter_mode == mavg_pkg::MODE_EMA) begin
        smooth <= smooth_next;
      end
      if (state == mavg_pkg::ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `CHK_NEXT(a_accept_loads, in_acc, state == mavg_pkg::ST_LOAD)
  `CHK_IMPLY(a_done_in_wait, div_rsp.done, state == mavg_pkg::ST_WAIT)
  `CHK_IMPLY(a_held_bounded, 1'b1, held <= n_eff)
  `CHK_NEXT(a_out_drains, m_tvalid && m_tready && state != mavg_pkg::ST_FINISH, !m_tvalid)

endmodule

/* verif/tb.sv */
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 650;
  localparam int QUIET_FROM     = 550;
  localparam int DRAIN_CYCLES   = 60;
  localparam int AW             = mavg_pkg::CFG_ADDR_W;
  localparam int CDW            = mavg_pkg::CFG_DATA_W;
  localparam int LW             = mavg_pkg::WIN_LEN_W;
  localparam int HIST_DEPTH     = mavg_pkg::MAX_WINDOW_DEF;
  localparam int HIST_IDX_W     = $clog2(HIST_DEPTH);
  localparam logic [AW-1:0] ADDR_MODE = AW'(4 * mavg_pkg::REG_FILTER_MODE);
  localparam logic [AW-1:0] ADDR_WLEN = AW'(4 * mavg_pkg::REG_WINDOW_LENGTH);

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                         kind;
    logic [AW-1:0]                     addr;
    logic [CDW-1:0]                    wdata;
    logic [mavg_pkg::SAMPLE_W-1:0]     sample;
    logic                              fixed;
    logic [mavg_pkg::SAMPLE_W-1:0]     result;
  } stim_row_t;

  localparam int DIR_ROWS = 27;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h0000, 1'b0, 16'h0000},
    '{ROW_WRITE,  ADDR_WLEN, 32'd1,         16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_WRITE,  ADDR_WLEN, 32'd0,         16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h5A5A, 1'b1, 16'h5A5A},
    '{ROW_WRITE,  ADDR_WLEN, 32'hAAAA_AA7F, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8000, 1'b0, 16'h0000},
    '{ROW_WRITE,  ADDR_WLEN, 32'd65,        16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h1234, 1'b1, 16'h1234},
    '{ROW_WRITE,  ADDR_MODE, 32'h5555_5555, 16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h7FFF, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8000, 1'b0, 16'h0000},
    '{ROW_WRITE,  ADDR_WLEN, 32'd1,         16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h7FFF, 1'b1, 16'h7FFF},
    '{ROW_WRITE,  ADDR_WLEN, 32'd2,         16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h7FFF, 1'b1, 16'h3FFF},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8001, 1'b0, 16'h0000},
    '{ROW_WRITE,  ADDR_WLEN, 32'd0,         16'h0000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, ADDR_MODE, 32'h0,         16'h8000, 1'b1, 16'h8000}
  };

  logic           clk;
  logic           rst      = 1'b1;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  logic [15:0]    s_tdata  = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  logic [15:0]    m_tdata;
  logic           psel     = 1'b0;
  logic           penable  = 1'b0;
  logic           pwrite   = 1'b0;
  logic [AW-1:0]  paddr    = '0;
  logic [CDW-1:0] pwdata   = '0;
  logic [CDW-1:0] prdata;
  logic           pready;

  moving_average_or_ema_filter_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic               cur_mode;
  logic [LW-1:0]      cur_len;
  logic signed [15:0] hist [HIST_DEPTH];
  int                 hist_ptr;
  int                 hist_count;
  longint             acc_sum;
  longint             ema_acc;

  logic [15:0] expected_samples [$];
  int          errors     = 0;
  int          random_cnt = 0;
  int          tx_rate    = 4;
  int          rx_rate    = 6;
  int          stall_left = 0;
  int          idle_cnt   = 0;
  bit          quiet      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void clear_filter();
    foreach (hist[i]) hist[i] = '0;
    hist_ptr   = 0;
    hist_count = 0;
    acc_sum    = 0;
    ema_acc    = 0;
  endfunction

  function automatic void apply_write(input logic [AW-1:0] addr,
                                      input logic [CDW-1:0] data);
    if (addr == ADDR_MODE) begin
      cur_mode = data[0];
      clear_filter();
    end else if (addr == ADDR_WLEN) begin
      cur_len = data[LW-1:0];
      clear_filter();
    end
  endfunction

  function automatic logic [15:0] next_filtered(input logic signed [15:0] x);
    int     n;
    longint target;
    n = (cur_len == 0) ? 1 : ((cur_len > HIST_DEPTH) ? HIST_DEPTH : int'(cur_len));
    if (cur_mode == mavg_pkg::MODE_BOXCAR) begin
      if (hist_count >= n) begin
        acc_sum -= hist[HIST_IDX_W'((hist_ptr + HIST_DEPTH - n) % HIST_DEPTH)];
      end else begin
        hist_count++;
      end
      hist[HIST_IDX_W'(hist_ptr)] = x;
      hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
      acc_sum += x;
      return 16'(acc_sum / hist_count);
    end else begin
      target = longint'(x) * 65536;
      ema_acc += (target - ema_acc) / n;
      return 16'(ema_acc >>> 16);
    end
  endfunction

  task automatic wait_drained();
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(input logic [AW-1:0] addr,
                           input logic [CDW-1:0] data);
    s_tvalid <= 1'b0;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_write(addr, data);
    @(posedge clk);
  endtask

  task automatic send_sample(input logic [15:0] x, input logic fixed,
                             input logic [15:0] fixed_val);
    logic [15:0] predicted;
    if (!quiet && tx_rate != 0 && $urandom_range(1, tx_rate) == 1) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= x;
    do @(posedge clk); while (!s_tready);
    predicted = next_filtered(x);
    expected_samples.insert(expected_samples.size(), fixed ? fixed_val : predicted);
  endtask

  function automatic logic [15:0] pick_sample(input logic [15:0] prev);
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 31)) - 16'd16;
      3:       return prev + 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LW-1:0] pick_length();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'(HIST_DEPTH);
      3:       return 7'($urandom_range(HIST_DEPTH + 1, 126));
      4:       return 7'd127;
      default: return 7'($urandom_range(1, HIST_DEPTH));
    endcase
  endfunction

  // The receiver stalls in bursts whose frequency changes from phase to phase.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && rx_rate != 0 && $urandom_range(1, rx_rate) == 1) begin
      m_tready <= 1'b0;
      stall_left = $urandom_range(1, 18) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample_out, expected none, got %h", $time, m_tdata);
        errors++;
      end else begin
        if (m_tdata !== expected_samples[0]) begin
          $display("%0t: sample_out mismatch, expected %h, got %h",
                   $time, expected_samples[0], m_tdata);
          errors++;
        end
        void'(expected_samples.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    int          batch;
    int          which;
    logic [15:0] prev;
    cur_mode = mavg_pkg::MODE_BOXCAR;
    cur_len  = mavg_pkg::WIN_LEN_RESET;
    clear_filter();
    prev = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        reg_write(DIRECTED[i].addr, DIRECTED[i].wdata);
      end else begin
        send_sample(DIRECTED[i].sample, DIRECTED[i].fixed, DIRECTED[i].result);
      end
    end

    // Each phase reconfigures the idle core and then streams a batch of samples.
    while (random_cnt < RANDOM_ITEMS) begin
      which = $urandom_range(0, 2);
      if (which != 1) begin
        reg_write(ADDR_MODE, {31'($urandom), 1'($urandom_range(0, 1))});
      end
      if (which != 0) begin
        reg_write(ADDR_WLEN, {25'($urandom), pick_length()});
      end
      case ($urandom_range(0, 2))
        0:       tx_rate = 0;
        1:       tx_rate = 3;
        default: tx_rate = 10;
      endcase
      case ($urandom_range(0, 2))
        0:       rx_rate = 0;
        1:       rx_rate = 4;
        default: rx_rate = 20;
      endcase
      batch = $urandom_range(10, 110);
      for (int k = 0; k < batch && random_cnt < RANDOM_ITEMS; k++) begin
        quiet = (random_cnt >= QUIET_FROM);
        prev = pick_sample(prev);
        send_sample(prev, 1'b0, '0);
        random_cnt++;
      end
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
